### hdl/kld_pkg.sv
// Shared types, constants and the logarithm table for the KL-divergence loss unit.
// Depends on nothing; every other file in hdl refers to it by scoped names.
package kld_pkg;

	// Probability format and logarithm table geometry.
	localparam int PROB_FRAC_BITS = 15;
	localparam int LOG_BITS       = 8;
	localparam int LOG_ENTRIES    = 1 << LOG_BITS;
	localparam int LN2_Q16        = 45426;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// Shared divider geometry.
	localparam int DVD_W  = 48;
	localparam int DVS_W  = 42;
	localparam int STEP_W = 6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_EPSILON      = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd1;
	localparam logic [1:0] CFG_GRAD_SCALE   = 2'd2;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic [15:0] target;
		logic [16:0] den;
		logic        t_zero;
		logic        last;
	} kld_entry_t;

	// Request to and response from the shared divider.
	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} kld_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} kld_div_rsp_t;

	typedef logic [15:0] kld_ln_rom_t [0:LOG_ENTRIES];

	// log2 of a Q30 value in [1, 2], as Q30; only used at elaboration.
	function automatic logic [63:0] log2_q30(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] y;
		x = x_in;
		y = 64'd0;
		if (x >= 2 * ONE_Q30) begin
			y = ONE_Q30;
			x = x >> 1;
		end
		for (int b = 29; b >= 0; b--) begin
			x = (x * x) >> 30;
			if (x >= 2 * ONE_Q30) begin
				x = x >> 1;
				y = y | (64'd1 << b);
			end
		end
		return y;
	endfunction

	// Table of ln(1 + i/N) in Q16, rounded to nearest.
	function automatic kld_ln_rom_t build_ln_rom();
		kld_ln_rom_t rom;
		logic [63:0] m;
		for (int i = 0; i <= LOG_ENTRIES; i++) begin
			m = (64'(LOG_ENTRIES) + 64'(i)) << (30 - LOG_BITS);
			rom[i] = 16'((log2_q30(m) * LN2_Q30 + (64'd1 << 43)) >> 44);
		end
		return rom;
	endfunction

	localparam kld_ln_rom_t LN_ROM = build_ln_rom();

endpackage

### hdl/kld_div.sv
// Shared restoring divider, one quotient bit per cycle, for the KL-divergence unit.
// Depends on kld_pkg for the request and response types.
module kld_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kld_pkg::kld_div_req_t req,
	output kld_pkg::kld_div_rsp_t rsp
);

	logic [kld_pkg::DVD_W-1:0]  dvd_q;
	logic [kld_pkg::DVS_W-1:0]  dvs_q;
	logic [kld_pkg::DVS_W:0]    rem_q;
	logic [kld_pkg::DVD_W-1:0]  quo_q;
	logic [kld_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [kld_pkg::DVS_W:0]    trial;
	logic                       fits;

	// The dividend arrives left-aligned, so each step takes its top bit.
	assign trial = {rem_q[kld_pkg::DVS_W-1:0], dvd_q[kld_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == kld_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data path of the divider.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[kld_pkg::DVD_W-2:0], 1'b0};
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
			quo_q <= {quo_q[kld_pkg::DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hdl/kld_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on kld_pkg for the entry type.
module kld_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kld_pkg::kld_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output kld_pkg::kld_entry_t head,
	output logic                empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	kld_pkg::kld_entry_t mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

### hdl/kld_front.sv
// Front part: takes input beats, forms the guarded denominator and flags the item.
// Depends on kld_pkg for the entry type.
module kld_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         epsilon,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,  // prediction [15:0], target_prob [31:16]
	input  logic                s_tlast,  // last_element
	output logic                push,
	output kld_pkg::kld_entry_t push_data,
	input  logic                full
);

	logic                valid_s1;
	kld_pkg::kld_entry_t entry_s1;
	logic [16:0]         den;
	logic                take;

	assign s_tready = !valid_s1 || !full;
	assign take     = s_tvalid && s_tready;

	// A zero denominator is taken as one LSB.
	always_comb begin
		den = {1'b0, s_tdata[15:0]} + {1'b0, epsilon};
		if (den == '0) begin
			den = 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.target <= s_tdata[31:16];
			entry_s1.den    <= den;
			entry_s1.t_zero <= s_tdata[31:16] == '0;
			entry_s1.last   <= s_tlast;
		end
	end

	assign push      = valid_s1;
	assign push_data = entry_s1;

endmodule

### hdl/kld_back.sv
// Back part: per item, ratio, logarithm, accumulation and gradient; loss on the last.
// Depends on kld_pkg for types, the logarithm table and divider geometry.
module kld_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           epsilon,
	input  logic [24:0]           sample_count,
	input  logic [23:0]           grad_scale,
	input  logic                  empty,
	input  kld_pkg::kld_entry_t   head,
	output logic                  pop,
	output kld_pkg::kld_div_req_t div_req,
	input  kld_pkg::kld_div_rsp_t div_rsp,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,  // gradient [31:0], loss_value [63:32]
	output logic                  m_tlast   // loss_valid
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_RDIV   = 14'b00000000000010,
		S_NORM   = 14'b00000000000100,
		S_ROM0   = 14'b00000000001000,
		S_ROM1   = 14'b00000000010000,
		S_LN     = 14'b00000000100000,
		S_TERM   = 14'b00000001000000,
		S_ACC    = 14'b00000010000000,
		S_GMUL   = 14'b00000100000000,
		S_GSTART = 14'b00001000000000,
		S_GDIV   = 14'b00010000000000,
		S_LSTART = 14'b00100000000000,
		S_LDIV   = 14'b01000000000000,
		S_OUT    = 14'b10000000000000
	} state_t;

	state_t        state_q;
	logic [15:0]   t_q;
	logic [16:0]   den_q;
	logic          last_q;
	logic [31:0]   n_q;
	logic [4:0]    k_q;
	logic [2:0]    nstep_q;
	logic [15:0]   lo_q;
	logic [37:0]   iprod_q;
	logic signed [21:0] ln_q;
	logic          neg_q;
	logic [36:0]   tprod_q;
	logic signed [47:0] acc_q;
	logic          acc_neg_q;
	logic [39:0]   num_q;
	logic [41:0]   dsc_q;
	logic [31:0]   grad_q;
	logic [31:0]   lossv_q;
	logic          lval_q;
	logic          out_v_q;

	logic [24:0]   sc_eff;
	logic [31:0]   ratio;
	logic [15:0]   hi;
	logic signed [6:0]  kexp;
	logic signed [21:0] ln_d;
	logic [20:0]   lmag;
	logic signed [48:0] sum;
	logic signed [47:0] term;
	logic [47:0]   amag;
	logic [47:0]   q;
	logic          load_out;

	assign sc_eff   = (sample_count == '0) ? 25'd1 : sample_count;
	assign pop      = (state_q == S_IDLE) && !empty;
	assign load_out = (state_q == S_OUT) && (!out_v_q || m_tready);
	assign q        = div_rsp.quotient;

	// Ratio plus epsilon, with a zero ratio taken as one LSB.
	always_comb begin
		ratio = {1'b0, q[30:0]} + {16'd0, epsilon};
		if (ratio == '0) begin
			ratio = 32'd1;
		end
	end

	// Divider requests: ratio, gradient and loss share the one unit.
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_IDLE: begin
				div_req.start    = !empty && !head.t_zero;
				div_req.dividend = {head.target, 32'd0};
				div_req.divisor  = 42'(head.den);
				div_req.steps    = kld_pkg::STEP_W'(31);
			end
			S_GSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = {num_q, 8'd0};
				div_req.divisor  = dsc_q;
				div_req.steps    = kld_pkg::STEP_W'(40);
			end
			S_LSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = amag;
				div_req.divisor  = 42'(sc_eff);
				div_req.steps    = kld_pkg::STEP_W'(48);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// Logarithm assembly: exponent times ln 2, table entry and interpolation.
	assign hi   = kld_pkg::LN_ROM[{1'b0, n_q[30:23]} + 9'd1];
	assign kexp = $signed({2'b00, k_q}) - 7'(kld_pkg::PROB_FRAC_BITS);
	assign ln_d = 22'(kexp) * 22'(kld_pkg::LN2_Q16) + $signed({6'd0, lo_q})
		+ $signed({6'd0, iprod_q[37:22]});
	assign lmag = ln_q[21] ? 21'(-ln_q) : ln_q[20:0];

	// Signed term and saturating accumulation.
	assign term = neg_q ? -$signed({26'd0, tprod_q[36:15]}) : $signed({26'd0, tprod_q[36:15]});
	assign sum  = {acc_q[47], acc_q} + {term[47], term};
	assign amag = acc_q[47] ? 48'(-acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q   <= '0;
			out_v_q <= 1'b0;
			nstep_q <= '0;
		end else begin
			if (m_tready && !load_out) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= head.t_zero ? S_ACC : S_RDIV;
					end
				end
				S_RDIV: begin
					if (div_rsp.done) begin
						state_q <= S_NORM;
						nstep_q <= '0;
					end
				end
				S_NORM: begin
					nstep_q <= nstep_q + 1'b1;
					if (nstep_q == 3'd4) begin
						state_q <= S_ROM0;
					end
				end
				S_ROM0:   state_q <= S_ROM1;
				S_ROM1:   state_q <= S_LN;
				S_LN:     state_q <= S_TERM;
				S_TERM:   state_q <= S_ACC;
				S_ACC: begin
					state_q <= S_GMUL;
					if (sum[48] != sum[47]) begin
						acc_q <= sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
					end else begin
						acc_q <= sum[47:0];
					end
				end
				S_GMUL:   state_q <= S_GSTART;
				S_GSTART: state_q <= S_GDIV;
				S_GDIV: begin
					if (div_rsp.done) begin
						state_q <= last_q ? S_LSTART : S_OUT;
					end
				end
				S_LSTART: begin
					state_q <= S_LDIV;
					acc_q   <= '0;
				end
				S_LDIV: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q     <= head.target;
				den_q   <= head.den;
				last_q  <= head.last;
				tprod_q <= '0;
				neg_q   <= 1'b0;
			end
			S_RDIV: begin
				n_q <= ratio;
				k_q <= 5'd31;
			end
			S_NORM: begin
				unique case (nstep_q)
					3'd0: if (n_q[31:16] == '0) begin
						n_q <= n_q << 16;
						k_q <= k_q - 5'd16;
					end
					3'd1: if (n_q[31:24] == '0) begin
						n_q <= n_q << 8;
						k_q <= k_q - 5'd8;
					end
					3'd2: if (n_q[31:28] == '0) begin
						n_q <= n_q << 4;
						k_q <= k_q - 5'd4;
					end
					3'd3: if (n_q[31:30] == '0) begin
						n_q <= n_q << 2;
						k_q <= k_q - 5'd2;
					end
					default: if (!n_q[31]) begin
						n_q <= n_q << 1;
						k_q <= k_q - 5'd1;
					end
				endcase
			end
			S_ROM0: lo_q <= kld_pkg::LN_ROM[{1'b0, n_q[30:23]}];
			S_ROM1: iprod_q <= 38'(hi - lo_q) * 38'(n_q[22:1]);
			S_LN:   ln_q <= ln_d;
			S_TERM: begin
				tprod_q <= 37'(t_q) * 37'(lmag);
				neg_q   <= ln_q[21];
			end
			S_GMUL: begin
				num_q <= 40'(t_q) * 40'(grad_scale);
				dsc_q <= 42'(den_q) * 42'(sc_eff);
				lossv_q <= '0;
				lval_q  <= last_q;
			end
			S_GDIV: begin
				if (div_rsp.done) begin
					grad_q <= (q > 48'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
				end
			end
			S_LSTART: acc_neg_q <= acc_q[47];
			S_LDIV: begin
				if (div_rsp.done) begin
					if (!acc_neg_q) begin
						lossv_q <= (q > 48'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
					end else begin
						lossv_q <= (q > 48'h80000000) ? 32'h80000000 : 32'(-q[31:0]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register; it holds while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {lossv_q, grad_q};
			m_tlast <= lval_q;
		end
	end

	assign m_tvalid = out_v_q;

endmodule

### hdl/kl_divergence_loss_and_gradient_unit.sv
// KL-divergence loss and gradient unit: one prediction/target pair in, one result out.
// Items enter on the s_ channel (prediction, target_prob in tdata, last_element on
// tlast) and results leave on the m_ channel (gradient, loss_value in tdata, loss_valid
// on tlast). Every beat in gives exactly one beat out, in order.
// Configuration is a plain write port: cfg_we, cfg_index (0 epsilon, 1 sample_count,
// 2 grad_scale), cfg_data; the user must write only while the unit is idle (unchecked).
// A front stage takes beats into a short queue, so input keeps flowing while the back
// part works and while a finished result waits on m_tready.
// The back part runs one item at a time through a shared divider that yields one
// quotient bit per cycle. An item is taken from the queue, then goes through the ratio
// division, normalisation, table look-up, log and accumulation, gradient setup,
// gradient division and the output load.
// A zero target skips the ratio and log; a last item adds a loss division before the
// output load.
// Reset clears the queue, the accumulator and the output valid, and restores epsilon
// to 1, sample_count to 1 and grad_scale to 1.0. When the receiver stalls the
// result holds in the output register, the back part waits, and the queue fills
// before s_tready drops.
module kl_divergence_loss_and_gradient_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // prediction [15:0], target_prob [31:16]
	input  logic        s_tlast,   // last_element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // gradient [31:0], loss_value [63:32]
	output logic        m_tlast    // loss_valid
);

	logic [15:0] epsilon_q;
	logic [24:0] sample_count_q;
	logic [23:0] grad_scale_q;

	logic                  push;
	kld_pkg::kld_entry_t   push_data;
	logic                  full;
	logic                  pop;
	kld_pkg::kld_entry_t   head;
	logic                  empty;
	kld_pkg::kld_div_req_t div_req;
	kld_pkg::kld_div_rsp_t div_rsp;

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q      <= 16'd1;
			sample_count_q <= 25'd1;
			grad_scale_q   <= 24'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kld_pkg::CFG_EPSILON:      epsilon_q      <= cfg_data[15:0];
				kld_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data;
				kld_pkg::CFG_GRAD_SCALE:   grad_scale_q   <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	kld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.epsilon   (epsilon_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	kld_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	kld_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	kld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.epsilon      (epsilon_q),
		.sample_count (sample_count_q),
		.grad_scale   (grad_scale_q),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.div_req      (div_req),
		.div_rsp      (div_rsp),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule
